// ===== design/urcu_pkg.sv =====
// ---------------------------------------------------------------------------
// urcu_pkg
// Shared status codes and reset constants of the ranger command unit.
// ---------------------------------------------------------------------------
`default_nettype none

package urcu_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_UNKNOWN  = 3'd1;
	localparam logic [2:0] ST_DISABLED = 3'd2;
	localparam logic [2:0] ST_GATE     = 3'd3;
	localparam logic [2:0] ST_NOMOD    = 3'd4;
	localparam logic [2:0] ST_NOECHO   = 3'd5;
	localparam logic [2:0] ST_OVFL     = 3'd6;

	localparam logic [6:0] ADDR_DEFAULT  = 7'h40;
	localparam logic [3:0] LIMIT_DEFAULT = 4'hf;

	localparam logic [1:0] CFG_RESTORE = 2'b10;
	localparam logic [1:0] SUB_CONFIG  = 2'd0;
	localparam logic [1:0] SUB_REBOOT  = 2'd1;
	localparam logic [1:0] GRP_MINMAX  = 2'd1;
	localparam logic [1:0] GRP_ENABLE  = 2'd2;

	localparam logic [14:0] WINDOW_NONE = 15'd16384;

endpackage

`default_nettype wire

// ===== design/ultrasonic_ranger_command_unit_top.sv =====
// ---------------------------------------------------------------------------
// ultrasonic_ranger_command_unit_top
// Command decoder and per-channel statistics store of a multi-channel ranger.
// ---------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low; it
// carries the command byte and the echo capture of the addressed channel.
// Per-channel peak, least and gate-pending state sit in one synchronous
// memory read at the accepting edge. The execute state decodes the command,
// writes the entry back and registers the reply; done is registered at the
// end of the execute state and is high for exactly one cycle, and busy is
// low again in that cycle, so a new request may be accepted while the reply
// is shown. The receiver cannot stall: done marks each reply for its one
// strobe cycle, and the reply ports hold it until the next request executes.
// Echo limits, the enable mask, the address and the lamp live in registers;
// restoring defaults rewrites the limits, the mask and the address at once.
// Reset (arst_n low) marks every memory entry as holding its reset value
// (peak 0, least all ones, gate clear), sets limits to 15, all channels
// enabled, address 0x40, lamp off. No clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module ultrasonic_ranger_command_unit_top #(
	parameter int NUM_CHANNELS = 8,
	parameter int READING_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  command_byte,
	input  wire logic [15:0] echo_ticks,
	input  wire logic        window_expired,
	input  wire logic        counter_overflow,
	input  wire logic        line_stuck,
	output logic             done,
	output logic [15:0]      reply_value,
	output logic [2:0]       status,
	output logic [14:0]      window_ticks,
	output logic             overflow_lamp,
	output logic [6:0]       bus_address
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int RB   = READING_BITS;
	localparam int EW   = 2 * RB + 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic acc;
	logic chv_in;

	logic [EW-1:0] mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;
	logic [3:0] lim_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] en_q;
	logic [6:0] addr_q;
	logic lamp_q;

	logic [7:0]    cmd_s1;
	logic [RB-1:0] ticks_s1;
	logic          exp_s1;
	logic          ovf_s1;
	logic          gto_s1;
	logic [EW-1:0] rd_s1;
	logic          vld_s1;

	logic [2:0]      ch;
	logic [CH_W-1:0] idx;
	logic            chv;
	logic [RB-1:0]   peak_c;
	logic [RB-1:0]   least_c;
	logic            gate_c;
	logic [RB-1:0]   peak_n;
	logic [RB-1:0]   least_n;
	logic            gate_n;
	logic            wr_en;
	logic [3:0]      lim_c;
	logic            lim_we;
	logic            restore;
	logic [3:0]      lim_after;
	logic [NUM_CHANNELS-1:0] en_n;
	logic [6:0]      addr_n;
	logic            lamp_n;
	logic [15:0]     reply_n;
	logic [2:0]      st_n;
	logic [14:0]     win_n;

	assign acc    = start && !busy;
	assign busy   = (state_q == S_EXEC);
	assign chv_in = ({1'b0, command_byte[2:0]} < 4'(NUM_CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done <= 1'b0;
					if (acc) begin
						state_q <= S_EXEC;
						vld_s1  <= chv_in && vld_q[command_byte[CH_W-1:0]];
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done    <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					done    <= 1'b0;
				end
			endcase
		end
	end

	// request capture and memory read
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1   <= command_byte;
			ticks_s1 <= echo_ticks[RB-1:0];
			exp_s1   <= window_expired;
			ovf_s1   <= counter_overflow;
			gto_s1   <= line_stuck;
			if (chv_in) begin
				rd_s1 <= mem[command_byte[CH_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && wr_en) begin
			mem[idx] <= {gate_n, least_n, peak_n};
		end
	end

	assign ch  = cmd_s1[2:0];
	assign idx = cmd_s1[CH_W-1:0];
	assign chv = ({1'b0, ch} < 4'(NUM_CHANNELS));

	always_comb begin
		if (vld_s1) begin
			gate_c  = rd_s1[EW-1];
			least_c = rd_s1[2*RB-1:RB];
			peak_c  = rd_s1[RB-1:0];
		end else begin
			gate_c  = 1'b0;
			least_c = '1;
			peak_c  = '0;
		end
	end

	assign lim_c = lim_q[idx];

	always_comb begin
		peak_n  = peak_c;
		least_n = least_c;
		gate_n  = gate_c;
		wr_en   = 1'b0;
		lim_we  = 1'b0;
		restore = 1'b0;
		en_n    = en_q;
		addr_n  = addr_q;
		lamp_n  = lamp_q;
		reply_n = '0;
		st_n    = urcu_pkg::ST_OK;
		if (cmd_s1[7]) begin
			if (!chv) begin
				st_n = urcu_pkg::ST_DISABLED;
			end else begin
				reply_n = 16'(lim_c);
				lim_we  = 1'b1;
			end
		end else if (cmd_s1[6:4] == 3'd0) begin
			if (!chv) begin
				st_n = urcu_pkg::ST_DISABLED;
			end else if (cmd_s1[3]) begin
				reply_n = 16'(lim_c);
			end else if (!en_q[idx]) begin
				st_n = urcu_pkg::ST_DISABLED;
			end else if (gate_c && gto_s1) begin
				st_n = urcu_pkg::ST_GATE;
			end else begin
				wr_en  = 1'b1;
				gate_n = 1'b0;
				if (exp_s1) begin
					if (ticks_s1 == '0) begin
						st_n = urcu_pkg::ST_NOMOD;
					end else begin
						st_n   = urcu_pkg::ST_NOECHO;
						gate_n = 1'b1;
						lamp_n = 1'b1;
					end
				end else if (ovf_s1) begin
					st_n   = urcu_pkg::ST_OVFL;
					gate_n = 1'b1;
					lamp_n = 1'b1;
				end else begin
					reply_n = 16'(ticks_s1);
					lamp_n  = 1'b0;
					if (ticks_s1 > peak_c) begin
						peak_n = ticks_s1;
					end
					if (ticks_s1 < least_c) begin
						least_n = ticks_s1;
					end
				end
			end
		end else if (cmd_s1[6:4] == 3'd1) begin
			if (cmd_s1[3:2] == urcu_pkg::SUB_CONFIG) begin
				restore = (cmd_s1[1:0] == urcu_pkg::CFG_RESTORE);
				if (restore) begin
					addr_n = urcu_pkg::ADDR_DEFAULT;
					en_n   = '1;
				end
			end else if (cmd_s1[3:2] != urcu_pkg::SUB_REBOOT) begin
				st_n = urcu_pkg::ST_UNKNOWN;
			end
		end else if (cmd_s1[6:5] == urcu_pkg::GRP_MINMAX) begin
			if (!chv) begin
				st_n = urcu_pkg::ST_DISABLED;
			end else if (cmd_s1[3]) begin
				wr_en = 1'b1;
				if (cmd_s1[4]) begin
					peak_n = '0;
				end else begin
					least_n = '1;
				end
			end else begin
				reply_n = cmd_s1[4] ? 16'(peak_c) : 16'(least_c);
			end
		end else if (cmd_s1[6:5] == urcu_pkg::GRP_ENABLE) begin
			if (!chv) begin
				st_n = urcu_pkg::ST_DISABLED;
			end else begin
				reply_n = 16'(en_q[idx]);
				if (cmd_s1[3]) begin
					en_n[idx] = cmd_s1[4];
				end
			end
		end else begin
			reply_n = 16'(addr_q);
			addr_n  = urcu_pkg::ADDR_DEFAULT | {2'b00, cmd_s1[4:0]};
		end
	end

	always_comb begin
		if (lim_we) begin
			lim_after = cmd_s1[6:3];
		end else if (restore) begin
			lim_after = urcu_pkg::LIMIT_DEFAULT;
		end else begin
			lim_after = lim_c;
		end
		if (chv) begin
			win_n = {5'({1'b0, lim_after} + 5'd1), 10'd0};
		end else begin
			win_n = urcu_pkg::WINDOW_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			en_q   <= '1;
			addr_q <= urcu_pkg::ADDR_DEFAULT;
			lamp_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				lim_q[i] <= urcu_pkg::LIMIT_DEFAULT;
			end
		end else if (state_q == S_EXEC) begin
			en_q   <= en_n;
			addr_q <= addr_n;
			lamp_q <= lamp_n;
			if (wr_en) begin
				vld_q[idx] <= 1'b1;
			end
			if (restore) begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					lim_q[i] <= urcu_pkg::LIMIT_DEFAULT;
				end
			end else if (lim_we) begin
				lim_q[idx] <= cmd_s1[6:3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			reply_value   <= reply_n;
			status        <= st_n;
			window_ticks  <= win_n;
			overflow_lamp <= lamp_n;
			bus_address   <= addr_n;
		end
	end

endmodule

`default_nettype wire

// ===== design/urcu_checker.sv =====
// ---------------------------------------------------------------------------
// urcu_checker
// Port-level checks of the ranger command unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module urcu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [15:0] reply_value,
	input wire logic [2:0]  status,
	input wire logic [14:0] window_ticks
);

	// every accepted request is answered by done after its execute state
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request not answered in two cycles");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy during reply strobe");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != urcu_pkg::ST_OK) |-> (reply_value == 16'd0))
		else $error("error reply carries data");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (window_ticks[9:0] == 10'd0 && window_ticks != 15'd0))
		else $error("window not a whole number of 1024-tick blocks");

endmodule

bind ultrasonic_ranger_command_unit_top urcu_checker u_urcu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.reply_value  (reply_value),
	.status       (status),
	.window_ticks (window_ticks)
);

`default_nettype wire
